@@ hdl/ipv6f_pkg.sv @@
// Shared types, constants and helper functions of the IPv6 text formatter.
// No dependencies; the front end, queue, emitter and top module import this package.
package ipv6f_pkg;

   localparam int NUM_GROUPS  = 8;
   localparam int QUEUE_DEPTH = 2;

   // Mark that tells an IPv4-mapped address in bits 63..32 of the low half.
   localparam logic [31:0] MAPPED_MARK = 32'h0000_FFFF;
   localparam logic [3:0]  NO_RUN      = 4'd8;

   localparam logic [6:0] CHAR_COLON = 7'h3a;
   localparam logic [6:0] CHAR_DOT   = 7'h2e;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;

   typedef logic [15:0] group_type;

   typedef struct packed {
      logic [1:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic [1:0] count;   // significant digits, 1..3
   } octet_type;

   typedef struct packed {
      logic                 quad;
      group_type [7:0]      groups;
      logic [3:0]           run_start;
      logic [3:0]           run_end;
      octet_type [3:0]      octets;
   } desc_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      case (nib)
         4'h0: c = 7'h30;
         4'h1: c = 7'h31;
         4'h2: c = 7'h32;
         4'h3: c = 7'h33;
         4'h4: c = 7'h34;
         4'h5: c = 7'h35;
         4'h6: c = 7'h36;
         4'h7: c = 7'h37;
         4'h8: c = 7'h38;
         4'h9: c = 7'h39;
         4'ha: c = 7'h61;
         4'hb: c = 7'h62;
         4'hc: c = 7'h63;
         4'hd: c = 7'h64;
         4'he: c = 7'h65;
         default: c = 7'h66;
      endcase
      return c;
   endfunction

   // Digits of a group with leading zeros dropped, 1..4
   function automatic logic [2:0] hex_count(input group_type g);
      logic [2:0] n;
      if (g[15:12] != 4'h0)
         n = 3'd4;
      else if (g[11:8] != 4'h0)
         n = 3'd3;
      else if (g[7:4] != 4'h0)
         n = 3'd2;
      else
         n = 3'd1;
      return n;
   endfunction

   // Byte to decimal digits; tens by reciprocal multiply (x*205>>11 exact below 100)
   function automatic octet_type dec_split(input logic [7:0] v);
      octet_type  o;
      logic [7:0] rem;
      logic [14:0] prod;
      if (v >= 8'd200) begin
         o.hund = 2'd2;
         rem    = v - 8'd200;
      end else if (v >= 8'd100) begin
         o.hund = 2'd1;
         rem    = v - 8'd100;
      end else begin
         o.hund = 2'd0;
         rem    = v;
      end
      prod    = 15'(rem[6:0]) * 15'd205;
      o.tens  = prod[14:11];
      o.units = 4'(rem - 8'(o.tens) * 8'd10);
      if (v >= 8'd100)
         o.count = 2'd3;
      else if (v >= 8'd10)
         o.count = 2'd2;
      else
         o.count = 2'd1;
      return o;
   endfunction

endpackage

@@ hdl/ipv6f_if.sv @@
// Handshake channel interfaces for addresses in and characters out.
// No dependencies.
interface ipv6f_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] addr_high;
   logic [63:0] addr_low;

   modport source (output valid, output addr_high, output addr_low, input ready);
   modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

interface ipv6f_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] text_char;
   logic       last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

@@ hdl/ipv6f_front.sv @@
// Front end: splits an address into groups, spots the mapped form, finds the
// longest zero run and splits the IPv4 bytes into digits. Uses ipv6f_pkg, ipv6f_req_if.
module ipv6f_front
   import ipv6f_pkg::*;
(
   ipv6f_req_if.sink  req,
   output logic       push_valid,
   input  logic       push_ready,
   output desc_type   push_data
);

   group_type [7:0] grp_w;
   octet_type [3:0] oct_w;
   logic            quad_w;
   logic [7:0]      zero_flags;
   logic [3:0]      run_start_w;
   logic [3:0]      run_end_w;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         grp_w[i]     = req.addr_high[48 - 16*i +: 16];
         grp_w[4 + i] = req.addr_low[48 - 16*i +: 16];
         oct_w[i]     = dec_split(req.addr_low[24 - 8*i +: 8]);
      end
   end

   assign quad_w = (req.addr_high == 64'd0) && (req.addr_low[63:32] == MAPPED_MARK);

   always_comb begin
      for (int i = 0; i < NUM_GROUPS; i++)
         zero_flags[i] = (grp_w[i] == 16'd0);
   end

   // Earliest longest run of two or more zero groups, none for a mapped address; strict compare keeps ties early
   always_comb begin
      logic [3:0] cur;
      logic [3:0] best;
      logic [3:0] rs;
      logic [3:0] re;
      cur  = 4'd0;
      best = 4'd0;
      rs   = NO_RUN;
      re   = NO_RUN;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         cur = zero_flags[i] ? cur + 4'd1 : 4'd0;
         if (cur >= 4'd2 && cur > best) begin
            best = cur;
            re   = 4'(i + 1);
            rs   = 4'(i + 1) - cur;
         end
      end
      if (quad_w) begin
         run_start_w = NO_RUN;
         run_end_w   = NO_RUN;
      end else begin
         run_start_w = rs;
         run_end_w   = re;
      end
   end

   assign push_data = '{quad: quad_w, groups: grp_w, run_start: run_start_w,
                        run_end: run_end_w, octets: oct_w};

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

@@ hdl/ipv6f_queue.sv @@
// Short register queue of classified addresses between front end and emitter.
// Uses ipv6f_pkg.
module ipv6f_queue
   import ipv6f_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  desc_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output desc_type pop_data,
   output logic [$clog2(Depth+1)-1:0] fill
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   desc_type            entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign fill       = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ hdl/ipv6f_emit.sv @@
// Emitter: walks a classified address and sends one character per cycle while the
// receiver is ready, through an output register. Uses ipv6f_pkg, ipv6f_rsp_if.
module ipv6f_emit
   import ipv6f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  desc_type  pop_data,
   output logic      busy,
   ipv6f_rsp_if.source rsp
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HEX  = 3'd1;
   localparam logic [2:0] ST_SEP  = 3'd2;
   localparam logic [2:0] ST_DC1  = 3'd3;
   localparam logic [2:0] ST_DC2  = 3'd4;
   localparam logic [2:0] ST_DEC  = 3'd5;
   localparam logic [2:0] ST_DOT  = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [2:0]      grp_ff, grp_in;
   logic [1:0]      dig_ff, dig_in;
   logic [1:0]      oct_ff, oct_in;
   group_type [7:0] groups_ff;
   octet_type [3:0] octets_ff;
   logic [3:0]      run_start_ff, run_end_ff;
   logic [6:0]      char_ff, char_in;
   logic            last_ff, last_in;
   logic            valid_ff, valid_in;

   logic            stall, advance, load;
   group_type       cur_grp;
   logic [2:0]      cur_cnt;
   logic [1:0]      nib_pos;
   logic [3:0]      nib;
   octet_type       cur_oct;
   logic [1:0]      dec_pos;
   logic [3:0]      dec_dig;
   logic [3:0]      next_grp;

   assign stall     = valid_ff && !rsp.ready;
   assign advance   = (state_ff != ST_IDLE) && !stall;
   assign pop_ready = (state_ff == ST_IDLE);
   assign load      = pop_valid && pop_ready;
   assign busy      = (state_ff != ST_IDLE);

   assign cur_grp  = groups_ff[grp_ff];
   assign cur_cnt  = hex_count(cur_grp);
   assign nib_pos  = 2'(3'd4 - cur_cnt) + dig_ff;
   assign nib      = cur_grp[4'd15 - {nib_pos, 2'b00} -: 4];
   assign next_grp = {1'b0, grp_ff} + 4'd1;

   assign cur_oct  = octets_ff[oct_ff];
   // digit place from the most significant of hundreds, tens, units
   assign dec_pos  = (2'd3 - cur_oct.count) + dig_ff;
   always_comb begin
      case (dec_pos)
         2'd0:    dec_dig = {2'b00, cur_oct.hund};
         2'd1:    dec_dig = cur_oct.tens;
         default: dec_dig = cur_oct.units;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      dig_in   = dig_ff;
      oct_in   = oct_ff;
      char_in  = char_ff;
      last_in  = 1'b0;
      if (load) begin
         grp_in = 3'd0;
         dig_in = 2'd0;
         oct_in = 2'd0;
         if (pop_data.quad)
            state_in = ST_DEC;
         else if (pop_data.run_start == 4'd0)
            state_in = ST_DC1;
         else
            state_in = ST_HEX;
      end else if (advance) begin
         unique case (state_ff)
            ST_HEX: begin
               char_in = hex_char(nib);
               if ({1'b0, dig_ff} == cur_cnt - 3'd1) begin
                  dig_in = 2'd0;
                  if (grp_ff == 3'd7) begin
                     last_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     grp_in   = next_grp[2:0];
                     state_in = (next_grp == run_start_ff) ? ST_DC1 : ST_SEP;
                  end
               end else begin
                  dig_in = dig_ff + 2'd1;
               end
            end
            ST_SEP: begin
               char_in  = CHAR_COLON;
               state_in = ST_HEX;
            end
            ST_DC1: begin
               char_in  = CHAR_COLON;
               state_in = ST_DC2;
            end
            ST_DC2: begin
               char_in = CHAR_COLON;
               if (run_end_ff == NO_RUN) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  grp_in   = run_end_ff[2:0];
                  dig_in   = 2'd0;
                  state_in = ST_HEX;
               end
            end
            ST_DEC: begin
               char_in = CHAR_ZERO + 7'(dec_dig);
               if (dig_ff == cur_oct.count - 2'd1) begin
                  dig_in = 2'd0;
                  if (oct_ff == 2'd3) begin
                     last_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_DOT;
                  end
               end else begin
                  dig_in = dig_ff + 2'd1;
               end
            end
            ST_DOT: begin
               char_in  = CHAR_DOT;
               oct_in   = oct_ff + 2'd1;
               state_in = ST_DEC;
            end
            default: state_in = ST_IDLE;
         endcase
      end
      if (!advance)
         last_in = last_ff;
   end

   always_comb begin
      if (advance)
         valid_in = 1'b1;
      else if (rsp.ready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      dig_ff  <= dig_in;
      oct_ff  <= oct_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (load) begin
         groups_ff    <= pop_data.groups;
         octets_ff    <= pop_data.octets;
         run_start_ff <= pop_data.run_start;
         run_end_ff   <= pop_data.run_end;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.text_char = char_ff;
   assign rsp.last_char = last_ff;

endmodule

@@ hdl/ipv6_text_formatter_unit.sv @@
// IPv6 address to canonical text, one ASCII character per cycle out while the receiver is ready.
// An address gives 2..39 characters; the queue takes new addresses meanwhile, but the
// emitter takes the next address from the queue only once it is idle again.
// Reset (synchronous, active high) empties the queue, idles the emitter and
// drops the output valid.
module ipv6_text_formatter_unit
   import ipv6f_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   ipv6f_req_if.sink   req_bus,
   ipv6f_rsp_if.source rsp_bus
);

   localparam int CntW = $clog2(QueueDepth + 1);

   logic            push_valid, push_ready;
   desc_type        push_data;
   logic            pop_valid, pop_ready;
   desc_type        pop_data;
   logic [CntW-1:0] fill;
   logic            emit_busy;

   ipv6f_front u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ipv6f_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .fill       (fill)
   );

   ipv6f_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .busy      (emit_busy),
      .rsp       (rsp_bus)
   );

   // an accepted address always finds room in the queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (fill < CntW'(QueueDepth)))
      else $error("address accepted into a full queue");

   // a new character appears only while the emitter is walking an address
   a_char_from_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(emit_busy))
      else $error("character offered with emitter idle");

   // every character lies in the span from dot to f, which holds digits, a..f, colon and dot
   a_char_range : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.text_char >= CHAR_DOT && rsp_bus.text_char <= 7'h66))
      else $error("character outside the address alphabet");

endmodule
